FILE: rtl/core/mcbpp_pkg.sv
// shared types and constants of the byte pipe pool
`timescale 1ns / 1ps

package mcbpp_pkg;

  localparam int unsigned PIPES_DEF     = 8;
  localparam int unsigned BUF_BYTES_DEF = 256;
  localparam int unsigned MAX_READ_DEF  = 64;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned HANDLE_W = 4;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 3'd0,
    STS_BAD    = 3'd1,
    STS_NOFREE = 3'd2,
    STS_BLOCK  = 3'd3,
    STS_EPIPE  = 3'd4,
    STS_EOF    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_EVAL = 3'b010,
    FSM_READ = 3'b100
  } fsm_e;

  // update request from the sequencer to the pipe table
  typedef struct packed {
    logic alloc;
    logic close_rd;
    logic close_wr;
    logic wr_byte;
    logic rd_done;
  } tbl_op_t;

  // flags of the selected pipe and of the pool
  typedef struct packed {
    logic in_use;
    logic reader_open;
    logic writer_open;
    logic any_free;
  } tbl_flags_t;

endpackage

FILE: rtl/core/mcbpp_store.sv
// byte ring buffer memory shared by all pipes
`timescale 1ns / 1ps

module mcbpp_store
  import mcbpp_pkg::*;
#(
  parameter int unsigned PIPES     = PIPES_DEF,
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF,
  localparam int unsigned PW       = (PIPES > 1) ? $clog2(PIPES) : 1,
  localparam int unsigned BW       = $clog2(BUF_BYTES),
  localparam int unsigned AW       = PW + BW
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = PIPES << BW;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mcbpp_table.sv
// per-pipe pointers, fill levels and open flags with free slot search
`timescale 1ns / 1ps

module mcbpp_table
  import mcbpp_pkg::*;
#(
  parameter int unsigned PIPES     = PIPES_DEF,
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF,
  localparam int unsigned PW       = (PIPES > 1) ? $clog2(PIPES) : 1,
  localparam int unsigned BW       = $clog2(BUF_BYTES),
  localparam int unsigned FW       = $clog2(BUF_BYTES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PW-1:0]    sel_i,
  input  tbl_op_t          op_i,
  input  logic [BW-1:0]    rd_ptr_new_i,
  input  logic [LEN_W-1:0] take_i,
  output tbl_flags_t       flags_o,
  output logic [BW-1:0]    wr_ptr_o,
  output logic [BW-1:0]    rd_ptr_o,
  output logic [FW-1:0]    fill_o,
  output logic [PW-1:0]    free_idx_o
);

  logic [BW-1:0] wp_q   [PIPES];
  logic [BW-1:0] rp_q   [PIPES];
  logic [FW-1:0] fill_q [PIPES];
  logic [PIPES-1:0] ro_q;
  logic [PIPES-1:0] wo_q;
  logic [PIPES-1:0] use_q;

  logic          sel_ok;
  logic [PW-1:0] free_idx;
  logic          any_free;
  logic [BW-1:0] wp_next;

  assign sel_ok = 32'(sel_i) < PIPES;

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = PIPES - 1; i >= 0; i--) begin
      if (!use_q[i]) begin
        free_idx = PW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    flags_o.in_use      = sel_ok && use_q[sel_i];
    flags_o.reader_open = sel_ok && ro_q[sel_i];
    flags_o.writer_open = sel_ok && wo_q[sel_i];
    flags_o.any_free    = any_free;
    wr_ptr_o = sel_ok ? wp_q[sel_i] : '0;
    rd_ptr_o = sel_ok ? rp_q[sel_i] : '0;
    fill_o   = sel_ok ? fill_q[sel_i] : '0;
  end

  assign free_idx_o = free_idx;
  assign wp_next = (wr_ptr_o == BW'(BUF_BYTES - 1)) ? '0 : wr_ptr_o + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPES; i++) begin
        wp_q[i]   <= '0;
        rp_q[i]   <= '0;
        fill_q[i] <= '0;
      end
      ro_q  <= '0;
      wo_q  <= '0;
      use_q <= '0;
    end else begin
      if (op_i.alloc) begin
        wp_q[free_idx]   <= '0;
        rp_q[free_idx]   <= '0;
        fill_q[free_idx] <= '0;
        ro_q[free_idx]   <= 1'b1;
        wo_q[free_idx]   <= 1'b1;
        use_q[free_idx]  <= 1'b1;
      end
      if (op_i.close_rd) begin
        ro_q[sel_i] <= 1'b0;
        if (!wo_q[sel_i]) begin
          use_q[sel_i] <= 1'b0;
        end
      end
      if (op_i.close_wr) begin
        wo_q[sel_i] <= 1'b0;
        if (!ro_q[sel_i]) begin
          use_q[sel_i] <= 1'b0;
        end
      end
      if (op_i.wr_byte) begin
        wp_q[sel_i]   <= wp_next;
        fill_q[sel_i] <= fill_o + 1'b1;
      end
      if (op_i.rd_done) begin
        rp_q[sel_i]   <= rd_ptr_new_i;
        fill_q[sel_i] <= fill_o - FW'(take_i);
      end
    end
  end

endmodule

FILE: rtl/core/multi_channel_byte_pipe_pool.sv
// top level of the byte pipe pool: command sequencer, pipe table and byte store
//
//   channel   direction  handshake             fields
//   command   in         start_i / busy_o      cmd_i handle_i request_length_i data_in_i
//   result    out        done_o strobe         status_o read_handle_o write_handle_o
//                                              data_out_o byte_count_o last_o
//
// allocate, close, write and a read that moves no byte pass the table lookup state and
// then the result register; the block is busy only during the lookup state
// a read of n bytes streams one byte per cycle out of the store read port
// reset is asynchronous and clears all pipes to free; the store needs no clearing
// each result shows for one cycle on done_o; the receiver cannot stall the block
`timescale 1ns / 1ps

module multi_channel_byte_pipe_pool
  import mcbpp_pkg::*;
#(
  parameter int unsigned PIPES     = PIPES_DEF,
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF,
  parameter int unsigned MAX_READ  = MAX_READ_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [LEN_W-1:0]    request_length_i,
  input  logic [DATA_W-1:0]   data_in_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] read_handle_o,
  output logic [HANDLE_W-1:0] write_handle_o,
  output logic [DATA_W-1:0]   data_out_o,
  output logic [LEN_W-1:0]    byte_count_o,
  output logic                last_o
);

  localparam int unsigned PW = (PIPES > 1) ? $clog2(PIPES) : 1;
  localparam int unsigned BW = $clog2(BUF_BYTES);
  localparam int unsigned FW = $clog2(BUF_BYTES + 1);
  localparam int unsigned AW = PW + BW;
  localparam int unsigned CW = (FW > LEN_W) ? FW : LEN_W;

  fsm_e fsm_d, fsm_q;

  cmd_e                cmd_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [LEN_W-1:0]    len_q;
  logic [DATA_W-1:0]   data_q;

  status_e             status_d, status_q;
  logic [HANDLE_W-1:0] rh_d, rh_q;
  logic [HANDLE_W-1:0] wh_d, wh_q;
  logic [LEN_W-1:0]    ocnt_d, ocnt_q;
  logic                done_d, done_q;

  logic [LEN_W-1:0] take_d, take_q;
  logic [LEN_W-1:0] bcnt_d, bcnt_q;
  logic [BW-1:0]    rp_d, rp_q;

  logic          accept;
  logic [PW-1:0] sel;
  logic          in_range;
  logic          live;
  logic          end_bit;
  logic [LEN_W-1:0] req_sat;
  logic [LEN_W-1:0] take;
  logic [LEN_W-1:0] bcnt_inc;
  logic          read_last;

  tbl_op_t       tbl_op;
  tbl_flags_t    tbl_flags;
  logic [BW-1:0] tbl_wp;
  logic [BW-1:0] tbl_rp;
  logic [FW-1:0] tbl_fill;
  logic [PW-1:0] free_idx;

  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  assign busy_o = (fsm_q != FSM_IDLE);
  assign accept = start_i && !busy_o;

  assign sel      = PW'(handle_q[HANDLE_W-1:1]);
  assign in_range = 32'(handle_q) < 2 * PIPES;
  assign live     = in_range && tbl_flags.in_use;
  assign end_bit  = handle_q[0];
  assign req_sat  = (32'(len_q) > MAX_READ) ? LEN_W'(MAX_READ) : len_q;
  assign take     = (CW'(req_sat) < CW'(tbl_fill)) ? req_sat : LEN_W'(tbl_fill);
  assign bcnt_inc = bcnt_q + 1'b1;
  assign read_last = (bcnt_inc == take_q);

  mcbpp_table #(
    .PIPES     (PIPES),
    .BUF_BYTES (BUF_BYTES)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sel_i        (sel),
    .op_i         (tbl_op),
    .rd_ptr_new_i (rp_q),
    .take_i       (take_q),
    .flags_o      (tbl_flags),
    .wr_ptr_o     (tbl_wp),
    .rd_ptr_o     (tbl_rp),
    .fill_o       (tbl_fill),
    .free_idx_o   (free_idx)
  );

  mcbpp_store #(
    .PIPES     (PIPES),
    .BUF_BYTES (BUF_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({sel, tbl_wp}),
    .wdata_i (data_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign mem_raddr = (fsm_q == FSM_EVAL) ? {sel, tbl_rp} : {sel, rp_q};

  always_comb begin
    fsm_d    = fsm_q;
    status_d = status_q;
    rh_d     = rh_q;
    wh_d     = wh_q;
    ocnt_d   = '0;
    done_d   = 1'b0;
    take_d   = take_q;
    bcnt_d   = bcnt_q;
    rp_d     = rp_q;
    tbl_op   = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    case (fsm_q)
      FSM_IDLE: begin
        if (accept) begin
          fsm_d = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        fsm_d    = FSM_IDLE;
        done_d   = 1'b1;
        status_d = STS_OK;
        rh_d     = '0;
        wh_d     = '0;
        case (cmd_q)
          CMD_ALLOC: begin
            if (tbl_flags.any_free) begin
              tbl_op.alloc = 1'b1;
              rh_d = HANDLE_W'({free_idx, 1'b0});
              wh_d = HANDLE_W'({free_idx, 1'b1});
            end else begin
              status_d = STS_NOFREE;
            end
          end
          CMD_CLOSE: begin
            if (!live) begin
              status_d = STS_BAD;
            end else if (end_bit) begin
              tbl_op.close_wr = 1'b1;
            end else begin
              tbl_op.close_rd = 1'b1;
            end
          end
          CMD_READ: begin
            if (!live || end_bit) begin
              status_d = STS_BAD;
            end else if (req_sat == '0) begin
              status_d = STS_OK;
            end else if (tbl_fill == '0) begin
              status_d = tbl_flags.writer_open ? STS_BLOCK : STS_EOF;
            end else begin
              done_d = 1'b0;
              fsm_d  = FSM_READ;
              mem_re = 1'b1;
              take_d = take;
              bcnt_d = '0;
              rp_d   = (tbl_rp == BW'(BUF_BYTES - 1)) ? '0 : tbl_rp + 1'b1;
            end
          end
          CMD_WRITE: begin
            if (!live || !end_bit) begin
              status_d = STS_BAD;
            end else if (!tbl_flags.reader_open) begin
              status_d = STS_EPIPE;
            end else if (tbl_fill == FW'(BUF_BYTES)) begin
              status_d = STS_BLOCK;
            end else begin
              mem_we         = 1'b1;
              tbl_op.wr_byte = 1'b1;
              ocnt_d         = LEN_W'(1);
            end
          end
          default: begin
            status_d = STS_BAD;
          end
        endcase
      end
      FSM_READ: begin
        if (read_last) begin
          tbl_op.rd_done = 1'b1;
          fsm_d = FSM_IDLE;
        end else begin
          mem_re = 1'b1;
          bcnt_d = bcnt_inc;
          rp_d   = (rp_q == BW'(BUF_BYTES - 1)) ? '0 : rp_q + 1'b1;
        end
      end
      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q  <= FSM_IDLE;
      done_q <= 1'b0;
    end else begin
      fsm_q  <= fsm_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_e'(cmd_i);
      handle_q <= handle_i;
      len_q    <= request_length_i;
      data_q   <= data_in_i;
    end
    status_q <= status_d;
    rh_q     <= rh_d;
    wh_q     <= wh_d;
    ocnt_q   <= ocnt_d;
    take_q   <= take_d;
    bcnt_q   <= bcnt_d;
    rp_q     <= rp_d;
  end

  assign done_o         = done_q || (fsm_q == FSM_READ);
  assign status_o       = status_q;
  assign read_handle_o  = rh_q;
  assign write_handle_o = wh_q;
  assign data_out_o     = (fsm_q == FSM_READ) ? mem_rdata : '0;
  assign byte_count_o   = (fsm_q == FSM_READ) ? bcnt_inc : ocnt_q;
  assign last_o         = (fsm_q == FSM_READ) ? read_last : done_q;

endmodule

FILE: verif/tb_multi_channel_byte_pipe_pool.sv
// testbench of the byte pipe pool: directed table and random commands
`timescale 1ns / 1ps

module tb_multi_channel_byte_pipe_pool
  import mcbpp_pkg::*;
();

  localparam int unsigned NPIPE        = PIPES_DEF;
  localparam int unsigned NBUF         = BUF_BYTES_DEF;
  localparam int unsigned NMAX         = MAX_READ_DEF;
  localparam int unsigned PTR_W        = $clog2(NBUF);
  localparam int unsigned RANDOM_ITEMS = 122;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = NMAX + 8;
  localparam int unsigned MAX_GAP      = 30;
  localparam int unsigned N_STEPS      = 28;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] alloc_rh;
    logic [HANDLE_W-1:0] alloc_wh;
    logic [DATA_W-1:0]   data;
    logic [LEN_W-1:0]    count;
    logic                last;
  } reply_t;

  typedef struct packed {
    cmd_e                cmd;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
    logic [DATA_W-1:0]   data;
    logic                fixed;
    status_e             status;
    logic [HANDLE_W-1:0] alloc_rh;
    logic [HANDLE_W-1:0] alloc_wh;
    logic [LEN_W-1:0]    count;
  } step_t;

  // fixed rows carry their single reply, the others are predicted
  localparam step_t STEPS [N_STEPS] = '{
    '{CMD_READ,  4'd0,  7'd1,   8'h00, 1'b1, STS_BAD,    4'd0,  4'd0,  7'd0},
    '{CMD_CLOSE, 4'd15, 7'd0,   8'h00, 1'b1, STS_BAD,    4'd0,  4'd0,  7'd0},
    '{CMD_ALLOC, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd0,  4'd1,  7'd0},
    '{CMD_READ,  4'd1,  7'd1,   8'h00, 1'b1, STS_BAD,    4'd0,  4'd0,  7'd0},
    '{CMD_WRITE, 4'd0,  7'd0,   8'hFF, 1'b1, STS_BAD,    4'd0,  4'd0,  7'd0},
    '{CMD_READ,  4'd0,  7'd5,   8'h00, 1'b1, STS_BLOCK,  4'd0,  4'd0,  7'd0},
    '{CMD_READ,  4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd0,  4'd0,  7'd0},
    '{CMD_WRITE, 4'd1,  7'd0,   8'h00, 1'b1, STS_OK,     4'd0,  4'd0,  7'd1},
    '{CMD_WRITE, 4'd1,  7'd127, 8'hFF, 1'b1, STS_OK,     4'd0,  4'd0,  7'd1},
    '{CMD_WRITE, 4'd1,  7'd0,   8'hA5, 1'b0, STS_OK,     4'd0,  4'd0,  7'd0},
    '{CMD_READ,  4'd0,  7'd127, 8'h00, 1'b0, STS_OK,     4'd0,  4'd0,  7'd0},
    '{CMD_WRITE, 4'd1,  7'd0,   8'h5A, 1'b0, STS_OK,     4'd0,  4'd0,  7'd0},
    '{CMD_CLOSE, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd0,  4'd0,  7'd0},
    '{CMD_READ,  4'd0,  7'd1,   8'h00, 1'b0, STS_OK,     4'd0,  4'd0,  7'd0},
    '{CMD_CLOSE, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd0,  4'd0,  7'd0},
    '{CMD_WRITE, 4'd1,  7'd0,   8'h3C, 1'b1, STS_EPIPE,  4'd0,  4'd0,  7'd0},
    '{CMD_ALLOC, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd2,  4'd3,  7'd0},
    '{CMD_ALLOC, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd4,  4'd5,  7'd0},
    '{CMD_ALLOC, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd6,  4'd7,  7'd0},
    '{CMD_ALLOC, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd8,  4'd9,  7'd0},
    '{CMD_ALLOC, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd10, 4'd11, 7'd0},
    '{CMD_ALLOC, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd12, 4'd13, 7'd0},
    '{CMD_ALLOC, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd14, 4'd15, 7'd0},
    '{CMD_ALLOC, 4'd0,  7'd0,   8'h00, 1'b1, STS_NOFREE, 4'd0,  4'd0,  7'd0},
    '{CMD_CLOSE, 4'd15, 7'd0,   8'h00, 1'b1, STS_OK,     4'd0,  4'd0,  7'd0},
    '{CMD_READ,  4'd14, 7'd64,  8'h00, 1'b1, STS_EOF,    4'd0,  4'd0,  7'd0},
    '{CMD_CLOSE, 4'd14, 7'd0,   8'h00, 1'b1, STS_OK,     4'd0,  4'd0,  7'd0},
    '{CMD_ALLOC, 4'd0,  7'd0,   8'h00, 1'b1, STS_OK,     4'd14, 4'd15, 7'd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [CMD_W-1:0]    cmd_i;
  logic [HANDLE_W-1:0] handle_i;
  logic [LEN_W-1:0]    request_length_i;
  logic [DATA_W-1:0]   data_in_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [HANDLE_W-1:0] read_handle_o;
  logic [HANDLE_W-1:0] write_handle_o;
  logic [DATA_W-1:0]   data_out_o;
  logic [LEN_W-1:0]    byte_count_o;
  logic                last_o;

  // pool mirror
  logic [DATA_W-1:0] pipe_bytes [NPIPE][NBUF];
  logic [PTR_W-1:0]  wr_ptr [NPIPE];
  logic [PTR_W-1:0]  rd_ptr [NPIPE];
  int unsigned       fill [NPIPE];
  logic              rd_open [NPIPE];
  logic              wr_open [NPIPE];
  logic              in_use [NPIPE];

  reply_t      pending_replies [$];
  reply_t      seen_reply;
  reply_t      want_reply;
  int unsigned idle_pct;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned commands_sent;
  int unsigned replies_checked;

  always #10 clk_i = ~clk_i;

  multi_channel_byte_pipe_pool dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .handle_i         (handle_i),
    .request_length_i (request_length_i),
    .data_in_i        (data_in_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .read_handle_o    (read_handle_o),
    .write_handle_o   (write_handle_o),
    .data_out_o       (data_out_o),
    .byte_count_o     (byte_count_o),
    .last_o           (last_o)
  );

  // applies one command to the mirror and appends the replies it causes
  task automatic pool_apply(input cmd_e c, input logic [HANDLE_W-1:0] h,
                            input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] d,
                            ref reply_t replies[$]);
    reply_t      r;
    int unsigned p;
    int unsigned n;
    int unsigned take;
    int unsigned k;
    bit          found;
    r = '0;
    r.status = STS_OK;
    r.last = 1'b1;
    p = h >> 1;
    case (c)
      CMD_ALLOC: begin
        found = 1'b0;
        for (k = 0; k < NPIPE && !found; k++) begin
          if (!in_use[k]) begin
            wr_ptr[k] = '0;
            rd_ptr[k] = '0;
            fill[k] = 0;
            rd_open[k] = 1'b1;
            wr_open[k] = 1'b1;
            in_use[k] = 1'b1;
            r.alloc_rh = HANDLE_W'(2 * k);
            r.alloc_wh = HANDLE_W'(2 * k + 1);
            found = 1'b1;
          end
        end
        if (!found) r.status = STS_NOFREE;
        replies.push_back(r);
      end
      CMD_CLOSE: begin
        if (h >= 2 * NPIPE || !in_use[p]) begin
          r.status = STS_BAD;
        end else begin
          if (h[0]) wr_open[p] = 1'b0;
          else rd_open[p] = 1'b0;
          if (!rd_open[p] && !wr_open[p]) in_use[p] = 1'b0;
        end
        replies.push_back(r);
      end
      CMD_READ: begin
        n = (len > NMAX) ? NMAX : len;
        if (h >= 2 * NPIPE || h[0] || !in_use[p]) begin
          r.status = STS_BAD;
          replies.push_back(r);
        end else if (n == 0) begin
          replies.push_back(r);
        end else if (fill[p] == 0) begin
          r.status = wr_open[p] ? STS_BLOCK : STS_EOF;
          replies.push_back(r);
        end else begin
          take = (n < fill[p]) ? n : fill[p];
          for (k = 0; k < take; k++) begin
            r.data = pipe_bytes[p][rd_ptr[p]];
            rd_ptr[p] = (rd_ptr[p] == NBUF - 1) ? '0 : rd_ptr[p] + 1'b1;
            r.count = LEN_W'(k + 1);
            r.last = (k + 1 == take);
            replies.push_back(r);
          end
          fill[p] -= take;
        end
      end
      default: begin
        if (h >= 2 * NPIPE || !h[0] || !in_use[p]) begin
          r.status = STS_BAD;
        end else if (!rd_open[p]) begin
          r.status = STS_EPIPE;
        end else if (fill[p] >= NBUF) begin
          r.status = STS_BLOCK;
        end else begin
          pipe_bytes[p][wr_ptr[p]] = d;
          wr_ptr[p] = (wr_ptr[p] == NBUF - 1) ? '0 : wr_ptr[p] + 1'b1;
          fill[p] += 1;
          r.count = LEN_W'(1);
        end
        replies.push_back(r);
      end
    endcase
  endtask

  // one command transfer, with a random idle gap in front
  task automatic send_command(input cmd_e c, input logic [HANDLE_W-1:0] h,
                              input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] d,
                              input bit fixed, input reply_t fixed_reply);
    reply_t      got [$];
    int unsigned gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i          <= 1'b1;
    cmd_i            <= c;
    handle_i         <= h;
    request_length_i <= len;
    data_in_i        <= d;
    do @(posedge clk_i); while (busy_o);
    pool_apply(c, h, len, d, got);
    if (fixed) pending_replies.push_back(fixed_reply);
    else foreach (got[i]) pending_replies.push_back(got[i]);
    commands_sent++;
  endtask

  // mostly commands on live pipes, some noise
  task automatic send_random;
    int unsigned      live [$];
    int unsigned      k;
    int unsigned      p;
    int unsigned      pick;
    int unsigned      sel;
    logic [LEN_W-1:0] len;
    for (k = 0; k < NPIPE; k++) if (in_use[k]) live.push_back(k);
    p = (live.size() != 0) ? live[$urandom_range(live.size() - 1)]
                           : $urandom_range(NPIPE - 1);
    sel = $urandom_range(9);
    if (sel == 0) len = '0;
    else if (sel == 1) len = LEN_W'(NMAX);
    else if (sel == 2) len = LEN_W'($urandom_range(127, NMAX + 1));
    else len = LEN_W'($urandom_range(8, 1));
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_command(cmd_e'($urandom_range(3)), HANDLE_W'($urandom_range(15)),
                   LEN_W'($urandom_range(127)), DATA_W'($urandom_range(255)), 1'b0, '0);
    end else if (pick < 18) begin
      send_command(CMD_ALLOC, HANDLE_W'($urandom_range(15)), len,
                   DATA_W'($urandom_range(255)), 1'b0, '0);
    end else if (pick < 26) begin
      send_command(CMD_CLOSE, HANDLE_W'(2 * p + $urandom_range(1)), len,
                   DATA_W'($urandom_range(255)), 1'b0, '0);
    end else if (pick < 62) begin
      send_command(CMD_WRITE, HANDLE_W'(2 * p + 1), len,
                   DATA_W'($urandom_range(255)), 1'b0, '0);
    end else begin
      send_command(CMD_READ, HANDLE_W'(2 * p), len,
                   DATA_W'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      seen_reply.status   = status_e'(status_o);
      seen_reply.alloc_rh = read_handle_o;
      seen_reply.alloc_wh = write_handle_o;
      seen_reply.data     = data_out_o;
      seen_reply.count    = byte_count_o;
      seen_reply.last     = last_o;
      if (pending_replies.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("reply with nothing pending: st=%0d rh=%0d wh=%0d data=%02h %s",
                   seen_reply.status, seen_reply.alloc_rh, seen_reply.alloc_wh,
                   seen_reply.data,
                   $sformatf("cnt=%0d last=%0d", seen_reply.count, seen_reply.last));
      end else begin
        want_reply = pending_replies.pop_front();
        replies_checked++;
        if (seen_reply !== want_reply) begin
          error_count++;
          if (error_count <= 10) begin
            $display("reply %0d mismatch: want st=%0d rh=%0d wh=%0d data=%02h cnt=%0d last=%0d",
                     replies_checked, want_reply.status, want_reply.alloc_rh,
                     want_reply.alloc_wh, want_reply.data, want_reply.count,
                     want_reply.last);
            $display("  got st=%0d rh=%0d wh=%0d data=%02h cnt=%0d last=%0d",
                     seen_reply.status, seen_reply.alloc_rh, seen_reply.alloc_wh,
                     seen_reply.data, seen_reply.count, seen_reply.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies pending", cycle_count,
               pending_replies.size());
      $display("tb_multi_channel_byte_pipe_pool: done, errors");
      $finish;
    end
  end

  initial begin
    reply_t      fixed_reply;
    int unsigned n;
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    cmd_i            = CMD_ALLOC;
    handle_i         = '0;
    request_length_i = '0;
    data_in_i        = '0;
    idle_pct         = 19;
    cycle_count      = 0;
    error_count      = 0;
    commands_sent    = 0;
    replies_checked  = 0;
    for (n = 0; n < NPIPE; n++) begin
      wr_ptr[n]  = '0;
      rd_ptr[n]  = '0;
      fill[n]    = 0;
      rd_open[n] = 1'b0;
      wr_open[n] = 1'b0;
      in_use[n]  = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < N_STEPS; n++) begin
      fixed_reply          = '0;
      fixed_reply.status   = STEPS[n].status;
      fixed_reply.alloc_rh = STEPS[n].alloc_rh;
      fixed_reply.alloc_wh = STEPS[n].alloc_wh;
      fixed_reply.count    = STEPS[n].count;
      fixed_reply.last     = 1'b1;
      send_command(STEPS[n].cmd, STEPS[n].handle, STEPS[n].len, STEPS[n].data,
                   STEPS[n].fixed, fixed_reply);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = (n < RANDOM_ITEMS / 3) ? 19 : (n < 2 * RANDOM_ITEMS / 3) ? 77 : 0;
      send_random;
    end
    start_i <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered: %0d command transfers (%0d random) with sender idle 19, 77 and 0 pct",
             commands_sent, RANDOM_ITEMS);
    $display("covered: %0d replies checked, bad handles, eof, broken pipe, no free pipe",
             replies_checked);
    if (error_count == 0) begin
      $display("tb_multi_channel_byte_pipe_pool: done, clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_multi_channel_byte_pipe_pool: done, errors");
    end
    $finish;
  end

endmodule
